[rtl/core/sfrp_pkg.sv]
package sfrp_pkg;

    // Operation codes carried on the slave-side tuser
    typedef enum logic [3:0] {
        OP_EXP2    = 4'd0,
        OP_EXP     = 4'd1,
        OP_LOG2    = 4'd2,
        OP_RCP     = 4'd3,
        OP_SQRT    = 4'd4,
        OP_RSQRT   = 4'd5,
        OP_SIN     = 4'd6,
        OP_COS     = 4'd7,
        OP_SIGMOID = 4'd8,
        OP_TANH    = 4'd9
    } t_op;

    localparam int unsigned POLY_W  = 27;
    localparam int unsigned EXPO_W  = 8;
    localparam int unsigned NORM_W  = 34;
    localparam int unsigned LZ_W    = 6;
    localparam int unsigned IN_TDATA_W  = 40;
    localparam int unsigned OUT_TDATA_W = 32;

    localparam logic [7:0] BIAS_UP    = 8'd127;  // exp2, exp, sqrt
    localparam logic [7:0] BIAS_DOWN  = 8'd126;  // rcp, rsqrt
    localparam logic [7:0] BASE_LOG2  = 8'd134;
    localparam logic [7:0] BASE_TRIG  = 8'd126;
    localparam logic [7:0] BASE_Q26   = 8'd127;  // tanh, sigmoid
    localparam logic [7:0] EXP_ONE    = 8'h7F;
    localparam logic [POLY_W-1:0] HALF_Q26 = 27'd33554432;  // 1 << 25

    typedef struct packed {
        t_op                       req_type;
        logic [POLY_W-1:0]         poly_value;
        logic signed [EXPO_W-1:0]  range_exponent;
        logic                      sign_bit;
    } t_item;

    // Leading-zero count of a 34-bit word (value for zero is don't-care)
    function automatic logic [LZ_W-1:0] lzc34(input logic [NORM_W-1:0] x);
        logic [LZ_W-1:0] z;
        z = '0;
        for (int i = 0; i < NORM_W; i++) begin
            if (x[i]) begin
                z = LZ_W'(NORM_W - 1 - i);
            end
        end
        return z;
    endfunction

endpackage

[rtl/core/sfrp_compose.sv]
module sfrp_compose (
    input  sfrp_pkg::t_item  i_item,
    output logic [31:0]      o_word
);
    import sfrp_pkg::*;

    logic [EXPO_W-1:0] e8;
    logic [22:0]       mant_direct;
    logic [NORM_W-1:0] log_v;
    logic [NORM_W-1:0] log_mag;
    logic [25:0]       sig_h;
    logic [POLY_W-1:0] sig_f;
    logic [NORM_W-1:0] norm_in;
    logic [NORM_W-1:0] norm;
    logic [LZ_W-1:0]   lz;
    logic [7:0]        norm_base;
    logic [7:0]        norm_exp;
    logic              norm_sign;
    logic [31:0]       norm_word;

    always_comb begin
        e8          = i_item.range_exponent;
        mant_direct = i_item.poly_value[24:2];

        // log2: exponent and fraction joined, bit 26 of the poly value ORed in
        log_v   = {e8, 26'd0} | {7'd0, i_item.poly_value};
        log_mag = e8[7] ? (~log_v + 34'd1) : log_v;

        // sigmoid: one half plus or minus half of tanh, floored at zero
        sig_h = i_item.poly_value[26:1];
        if (i_item.sign_bit) begin
            sig_f = ({1'b0, sig_h} > HALF_Q26) ? '0 : (HALF_Q26 - {1'b0, sig_h});
        end else begin
            sig_f = HALF_Q26 + {1'b0, sig_h};
        end

        // operand for the shared normaliser, left-aligned in 34 bits
        unique case (i_item.req_type) inside
            OP_LOG2: begin
                norm_in   = log_mag;
                norm_base = BASE_LOG2;
                norm_sign = e8[7];
            end
            OP_SIN, OP_COS: begin
                norm_in   = {i_item.poly_value[25:0], 8'd0};
                norm_base = BASE_TRIG;
                norm_sign = i_item.sign_bit;
            end
            OP_TANH: begin
                norm_in   = {i_item.poly_value, 7'd0};
                norm_base = BASE_Q26;
                norm_sign = i_item.sign_bit;
            end
            OP_SIGMOID: begin
                norm_in   = {sig_f, 7'd0};
                norm_base = BASE_Q26;
                norm_sign = 1'b0;
            end
            default: begin
                norm_in   = '0;
                norm_base = '0;
                norm_sign = 1'b0;
            end
        endcase

        lz        = lzc34(norm_in);
        norm      = norm_in << lz;
        norm_exp  = norm_base - 8'(lz);
        norm_word = (norm_in == '0) ? {norm_sign, 31'd0}
                                    : {norm_sign, norm_exp, norm[32:10]};

        unique case (i_item.req_type) inside
            OP_EXP2, OP_EXP, OP_SQRT: o_word = {1'b0, BIAS_UP + e8, mant_direct};
            OP_RCP:   o_word = {i_item.sign_bit, BIAS_DOWN - e8, mant_direct};
            OP_RSQRT: o_word = {1'b0, BIAS_DOWN - e8, mant_direct};
            OP_LOG2, OP_TANH, OP_SIGMOID: o_word = norm_word;
            OP_SIN, OP_COS: begin
                // overflow bit: exactly plus or minus one
                o_word = i_item.poly_value[26] ? {i_item.sign_bit, EXP_ONE, 23'd0}
                                               : norm_word;
            end
            default: o_word = '0;
        endcase
    end

endmodule

[rtl/core/special_function_result_packer.sv]
// Channel  | Dir | Fields (tdata / tuser, low bit first)                      | Beat rule
// s_axis   | in  | tdata: poly_value[26:0], range_exponent[34:27],           | tvalid & tready
//          |     |        sign_bit[35], zero[39:36]; tuser: req_type[3:0]    |
// m_axis   | out | tdata: fp32_word[31:0]                                    | tvalid & tready
//
// Two register stages: input register, then compose logic, then result register.
// One beat per cycle sustained while m_axis_tready stays high; each beat passes through the
// input register and then the result register before it is offered on m_axis.
// The 34-bit leading-zero count and shift in the compose path set the clock period.
// Reset (synchronous, active low) empties both stages; payload registers are not reset.
// A stalled result holds; s_axis_tready is high while the input stage is empty or can move on.
module special_function_result_packer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // poly_value[26:0], range_exponent[34:27], sign_bit[35], pad[39:36]
    input  logic [sfrp_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // req_type[3:0]
    input  logic [3:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // fp32_word[31:0]
    output logic [sfrp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import sfrp_pkg::*;

    logic        r_in_valid;
    t_item       r_in_item;
    t_item       n_in_item;
    logic        r_out_valid;
    logic [31:0] r_out_word;
    logic [31:0] n_out_word;
    logic        w_out_adv;
    logic        w_in_adv;

    // stage moves when its successor is empty or being drained
    assign w_out_adv     = !r_out_valid || m_axis_tready;
    assign w_in_adv      = !r_in_valid || w_out_adv;
    assign s_axis_tready = w_in_adv;

    // unpack the beat
    always_comb begin
        n_in_item.req_type       = t_op'(s_axis_tuser);
        n_in_item.poly_value     = s_axis_tdata[26:0];
        n_in_item.range_exponent = s_axis_tdata[34:27];
        n_in_item.sign_bit       = s_axis_tdata[35];
    end

    sfrp_compose u_compose (
        .i_item (r_in_item),
        .o_word (n_out_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_adv) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_out_adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_adv && s_axis_tvalid) begin
            r_in_item <= n_in_item;
        end
        if (w_out_adv && r_in_valid) begin
            r_out_word <= n_out_word;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_word;

endmodule

[rtl/core/sfrp_checker.sv]
module sfrp_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    input  logic [3:0]                        s_axis_tuser,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [sfrp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import sfrp_pkg::*;

    logic w_in_beat;
    assign w_in_beat = s_axis_tvalid && s_axis_tready;

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // a ready sink never stalls the source
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("source stalled with sink ready");

    // result valid after the input and result registers when the sink keeps up
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_beat ##1 m_axis_tready |=> m_axis_tvalid)
        else $error("result missing two cycles after input beat");

    // unused operation codes give a zero word
    a_unused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_beat && s_axis_tuser > 4'(OP_TANH)) ##1 m_axis_tready |=> m_axis_tdata == '0)
        else $error("unused operation code gave non-zero word");

    // reset empties the pipeline
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind special_function_result_packer sfrp_checker u_sfrp_checker (.*);
